// ===== hw/rtl/bidso_pkg.sv =====
// ---------------------------------------------------------------------------
// bidso_pkg: shared types and constants for the bounded ID set
// Table entry layout, sequencer states and command codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bidso_pkg;

  localparam int unsigned ID_W    = 32;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned LIMIT_W = 8;

  // stamp = seconds * STAMP_SCALE + marker
  localparam logic [6:0] STAMP_SCALE = 7'd100;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd100;

  localparam logic [OP_W-1:0] OP_CHECK  = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  typedef struct packed {
    logic               valid;
    logic [ID_W-1:0]    id;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE,
    ST_WRITE2
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bounded_id_set_oldest_evict.sv =====
// ---------------------------------------------------------------------------
// bounded_id_set_oldest_evict: bounded ID set with oldest-stamp eviction
// Holds up to TABLE_DEPTH IDs with time stamps; check, add/refresh, remove.
// ---------------------------------------------------------------------------
// A command item is taken when start is high and busy is low. Every item,
// whatever its opcode, makes one full pass over the table, one slot per
// cycle through the single registered read port of the entry memory, and an
// item keeps busy high through the scan, the resolve step and, when an add
// both drops a slot and stores into an earlier free one, a second memory
// write. The result appears for exactly one cycle with out_valid high;
// the receiver cannot stall it, so it must take it then.
// After reset the block sweeps the memory once to mark all slots empty,
// with busy high during the sweep. The capacity limit can be written
// at any time through the cfg channel (cfg_ready is always high) but should
// only be changed while no command is in flight.
`timescale 1ns / 1ps
`default_nettype none

module bounded_id_set_oldest_evict #(
  parameter int unsigned TABLE_DEPTH = 128
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // command channel
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [bidso_pkg::OP_W-1:0]      in_opcode,
  input  wire logic [bidso_pkg::ID_W-1:0]      in_vid,
  input  wire logic [31:0]                     in_now_seconds,
  // result channel
  output logic                                 out_valid,
  output logic                                 out_success,
  output logic                                 out_evicted,
  output logic [bidso_pkg::ID_W-1:0]           out_evicted_vid,
  // capacity limit register write
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bidso_pkg::LIMIT_W-1:0]   cfg_data
);

  localparam int unsigned AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMPW = (CW > bidso_pkg::LIMIT_W) ? CW : bidso_pkg::LIMIT_W;

  // --- state --------------------------------------------------------------
  bidso_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]                       cnt_r, cnt_nxt;     // sweep / scan counter
  logic [CW-1:0]                       count_r, count_nxt; // valid entries
  logic [bidso_pkg::STAMP_W-1:0]       marker_r;
  logic [bidso_pkg::LIMIT_W-1:0]       limit_r;

  // latched command
  logic [bidso_pkg::OP_W-1:0]          op_r;
  logic [bidso_pkg::ID_W-1:0]          vid_r;
  logic [bidso_pkg::STAMP_W-1:0]       stamp_r;

  // scan trackers
  logic                                match_found_r;
  logic [AW-1:0]                       match_idx_r;
  logic [bidso_pkg::STAMP_W-1:0]       match_stamp_r;
  logic                                free_found_r;
  logic [AW-1:0]                       free_idx_r;
  logic                                vic_found_r;
  logic [AW-1:0]                       vic_idx_r;
  logic [bidso_pkg::STAMP_W-1:0]       vic_stamp_r;
  logic [bidso_pkg::ID_W-1:0]          vic_id_r;

  logic [AW-1:0]                       w2_idx_r, w2_idx_nxt;

  // result registers
  logic                                out_valid_r;
  logic                                success_r, success_nxt;
  logic                                evicted_r, evicted_nxt;
  logic [bidso_pkg::ID_W-1:0]          evid_r, evid_nxt;

  // --- entry memory ---------------------------------------------------------
  bidso_pkg::entry_t mem [TABLE_DEPTH];
  bidso_pkg::entry_t rd_data_r;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  bidso_pkg::entry_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // --- handshakes -------------------------------------------------------------
  logic accept;
  assign busy      = (state_r != bidso_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Scan: counter issues reads for slots 0..DEPTH-1; the slot evaluated in a
  // cycle is the one read in the previous cycle (cnt - 1).
  logic          scan_eval;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] scan_slot;
  assign scan_eval = (state_r == bidso_pkg::ST_SCAN) && (cnt_r != '0);
  assign cnt_m1    = cnt_r - CW'(1);
  assign scan_slot = cnt_m1[AW-1:0];
  assign rd_en     = (state_r == bidso_pkg::ST_SCAN) && (cnt_r < CW'(TABLE_DEPTH));
  assign rd_addr   = cnt_r[AW-1:0];

  // --- resolve decision (uses finished trackers) ------------------------------
  logic          full;
  logic          drop_ok, tgt_ok, store_new;
  logic [AW-1:0] drop_idx, tgt_idx;

  // Physically full also forces eviction, even above the limit.
  assign full = (CMPW'(count_r) >= CMPW'(limit_r)) || (count_r >= CW'(TABLE_DEPTH));

  always_comb begin
    drop_ok     = 1'b0;
    drop_idx    = match_idx_r;
    tgt_ok      = 1'b0;
    tgt_idx     = free_idx_r;
    store_new   = 1'b0;
    success_nxt = 1'b0;
    evicted_nxt = 1'b0;
    evid_nxt    = '0;
    unique case (op_r)
      bidso_pkg::OP_CHECK: begin
        success_nxt = match_found_r && (match_stamp_r != '0);
      end
      bidso_pkg::OP_REMOVE: begin
        drop_ok     = match_found_r;
        success_nxt = match_found_r;
      end
      bidso_pkg::OP_ADD: begin
        success_nxt = 1'b1;
        if (full) begin
          // a matching ID is dropped and re-stored; otherwise the first
          // oldest entry goes, and is reported
          if (match_found_r) begin
            drop_ok  = 1'b1;
            drop_idx = match_idx_r;
          end else if (vic_found_r) begin
            drop_ok     = 1'b1;
            drop_idx    = vic_idx_r;
            evicted_nxt = 1'b1;
            evid_nxt    = vic_id_r;
          end
          // store goes to the lowest empty slot after the drop
          if (drop_ok) begin
            tgt_ok    = 1'b1;
            store_new = 1'b1;
            tgt_idx   = (free_found_r && (free_idx_r < drop_idx)) ? free_idx_r : drop_idx;
          end else begin
            tgt_ok    = free_found_r;
            store_new = free_found_r;
            tgt_idx   = free_idx_r;
          end
        end else if (match_found_r) begin
          // refresh in place
          tgt_ok  = 1'b1;
          tgt_idx = match_idx_r;
        end else begin
          tgt_ok    = free_found_r;
          store_new = free_found_r;
          tgt_idx   = free_idx_r;
        end
      end
      default: begin
        // unused opcode: no change, all-zero result
      end
    endcase
  end

  // --- sequencer ----------------------------------------------------------------
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    count_nxt  = count_r;
    w2_idx_nxt = w2_idx_r;
    wr_en      = 1'b0;
    wr_addr    = cnt_r[AW-1:0];
    wr_data    = '0;
    unique case (state_r)
      bidso_pkg::ST_CLEAR: begin
        // mark every slot empty after reset
        wr_en   = 1'b1;
        wr_addr = cnt_r[AW-1:0];
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(TABLE_DEPTH - 1)) begin
          state_nxt = bidso_pkg::ST_IDLE;
          cnt_nxt   = '0;
        end
      end
      bidso_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = bidso_pkg::ST_SCAN;
          cnt_nxt   = '0;
        end
      end
      bidso_pkg::ST_SCAN: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(TABLE_DEPTH)) begin
          state_nxt = bidso_pkg::ST_RESOLVE;
        end
      end
      bidso_pkg::ST_RESOLVE: begin
        count_nxt = count_r - CW'(drop_ok && (count_r != '0)) + CW'(store_new);
        state_nxt = bidso_pkg::ST_IDLE;
        if (tgt_ok) begin
          wr_en         = 1'b1;
          wr_addr       = tgt_idx;
          wr_data.valid = 1'b1;
          wr_data.id    = vid_r;
          wr_data.stamp = stamp_r;
          if (drop_ok && (drop_idx != tgt_idx)) begin
            w2_idx_nxt = drop_idx;
            state_nxt  = bidso_pkg::ST_WRITE2;
          end
        end else if (drop_ok) begin
          wr_en   = 1'b1;
          wr_addr = drop_idx;
        end
      end
      bidso_pkg::ST_WRITE2: begin
        // clear the dropped slot
        wr_en     = 1'b1;
        wr_addr   = w2_idx_r;
        state_nxt = bidso_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = bidso_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bidso_pkg::ST_CLEAR;
      cnt_r       <= '0;
      count_r     <= '0;
      marker_r    <= '0;
      limit_r     <= bidso_pkg::LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      count_r     <= count_nxt;
      out_valid_r <= (state_r == bidso_pkg::ST_RESOLVE);
      if ((state_r == bidso_pkg::ST_RESOLVE) && (op_r == bidso_pkg::OP_ADD)) begin
        marker_r <= marker_r + 32'd1;
      end
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
    end
  end

  // --- command latch, trackers, result ------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r          <= in_opcode;
      vid_r         <= in_vid;
      stamp_r       <= 32'(in_now_seconds * bidso_pkg::STAMP_SCALE) + marker_r;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      vic_found_r   <= 1'b0;
    end else if (scan_eval) begin
      if (!rd_data_r.valid) begin
        if (!free_found_r) begin
          free_found_r <= 1'b1;
          free_idx_r   <= scan_slot;
        end
      end else if (!match_found_r) begin
        if (rd_data_r.id == vid_r) begin
          match_found_r <= 1'b1;
          match_idx_r   <= scan_slot;
          match_stamp_r <= rd_data_r.stamp;
        end else if (!vic_found_r || (rd_data_r.stamp < vic_stamp_r)) begin
          // strict compare keeps the first of equal stamps
          vic_found_r <= 1'b1;
          vic_idx_r   <= scan_slot;
          vic_stamp_r <= rd_data_r.stamp;
          vic_id_r    <= rd_data_r.id;
        end
      end
    end
    w2_idx_r <= w2_idx_nxt;
    if (state_r == bidso_pkg::ST_RESOLVE) begin
      success_r <= success_nxt;
      evicted_r <= evicted_nxt;
      evid_r    <= evid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_success     = success_r;
  assign out_evicted     = evicted_r;
  assign out_evicted_vid = evid_r;

endmodule

`default_nettype wire
